@@ sv/kmc_pkg.sv @@
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants of the k-means clustering engine: request and
// register codes, datapath command and status types, parameter defaults.
// ----------------------------------------------------------------------------
package kmc_pkg;

   localparam int DEF_MAX_POINTS   = 1024;
   localparam int DEF_MAX_DIMS     = 16;
   localparam int DEF_MAX_CLUSTERS = 16;
   localparam int DEF_COORD_WIDTH  = 16;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_RUN  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [1:0] CSR_POINT_COUNT     = 2'd0;
   localparam logic [1:0] CSR_DIMENSIONS      = 2'd1;
   localparam logic [1:0] CSR_CLUSTER_COUNT   = 2'd2;
   localparam logic [1:0] CSR_ITERATION_COUNT = 2'd3;

   localparam logic [10:0] RST_POINT_COUNT     = 11'd1024;
   localparam logic [4:0]  RST_DIMENSIONS      = 5'd16;
   localparam logic [4:0]  RST_CLUSTER_COUNT   = 5'd4;
   localparam logic [7:0]  RST_ITERATION_COUNT = 8'd10;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,       // write one point coordinate from the request
      OP_READ,       // read the assignment of the requested point
      OP_ASG_CLR,    // zero one assignment entry
      OP_SEED_RD,    // read a point coordinate for seeding
      OP_SEED_WR,    // copy it to the centroid
      OP_CLR_SUM,    // zero a sum entry, and the count on the first dimension
      OP_DIST_RD,    // read point and centroid coordinate
      OP_DIST_DIFF,
      OP_DIST_SQ,
      OP_DIST_ACC,
      OP_DIST_CMP,   // keep the nearest centroid so far
      OP_ASG_WR,     // store winner, read its count
      OP_CNT_WR,
      OP_SUMA_RD,
      OP_SUMA_WR,
      OP_CNT_RD,
      OP_UPD_RD,
      OP_DIV_START,
      OP_UPD_WR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      first;
   } dp_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic div_done;
   } dp_sts_type;

endpackage

@@ sv/kmeans_clustering_engine.sv @@
// ----------------------------------------------------------------------------
// kmeans_clustering_engine
// Lloyd k-means clustering over stored signed fixed-point points.
// ----------------------------------------------------------------------------
// Usage: the req channel takes load, run and read transactions. A load writes
// one coordinate of a stored point and gives no response. A read loads the
// cluster of a point into the assignment read register, then S_READ_WAIT
// puts it on the rsp channel. A run seeds centroid c from point c, then makes
// iteration_count assign and update passes, then returns one rsp transaction
// with run_done set. A pass walks every point through the distance multiplier
// one coordinate at a time for the assignment, then forms the means with the
// one-bit-per-cycle divider on sums of SW bits, SW being the sum width
// (COORD_WIDTH plus count width, 27 at the defaults).
// After reset the engine zeroes every entry of the assignment memory with
// req_ready low; configuration writes are taken meanwhile.
// One response register sits on the rsp side; while it holds a transaction
// that is not taken, req_ready stays low and no new request is accepted.
// ----------------------------------------------------------------------------
module kmeans_clustering_engine
   import kmc_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_DIMS     = DEF_MAX_DIMS,
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [9:0]         req_point_index,
   input  logic [3:0]         req_coord_index,
   input  logic signed [15:0] req_coord_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_cluster_index,
   output logic               rsp_run_done,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_write_data
);

   localparam int PIW = $clog2(MAX_POINTS);
   localparam int CIW = $clog2(MAX_CLUSTERS);
   localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   dp_cmd_type     cmd;
   dp_sts_type     sts;
   logic [PIW-1:0] pt_idx;
   logic [CIW-1:0] cl_idx;
   logic [DIW-1:0] dim_idx;
   logic [CIW-1:0] asg_data;
   logic           asg_valid;

   kmc_control #(
      .MAX_POINTS   (MAX_POINTS),
      .MAX_DIMS     (MAX_DIMS),
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_control (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_run_done     (rsp_run_done),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .pt_idx           (pt_idx),
      .cl_idx           (cl_idx),
      .dim_idx          (dim_idx),
      .sts              (sts)
   );

   kmc_datapath #(
      .MAX_POINTS   (MAX_POINTS),
      .MAX_DIMS     (MAX_DIMS),
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .pt_idx          (pt_idx),
      .cl_idx          (cl_idx),
      .dim_idx         (dim_idx),
      .req_point_index (req_point_index),
      .req_coord_index (req_coord_index),
      .req_coord_value (req_coord_value),
      .sts             (sts),
      .asg_data        (asg_data),
      .asg_valid       (asg_valid)
   );

   // run acknowledgements and reads beyond the store report cluster zero
   assign rsp_cluster_index = (rsp_run_done || !asg_valid) ? 4'd0 : 4'(asg_data);

endmodule

@@ sv/kmc_datapath.sv @@
// ----------------------------------------------------------------------------
// kmc_datapath
// Point, centroid, sum, count and assignment memories, the distance
// accumulator with nearest-centroid select, and a serial mean divider.
// ----------------------------------------------------------------------------
module kmc_datapath
   import kmc_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_DIMS     = DEF_MAX_DIMS,
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   parameter int COORD_WIDTH  = DEF_COORD_WIDTH,
   localparam int PIW  = $clog2(MAX_POINTS),
   localparam int CIW  = $clog2(MAX_CLUSTERS),
   localparam int DIW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic [PIW-1:0]      pt_idx,
   input  logic [CIW-1:0]      cl_idx,
   input  logic [DIW-1:0]      dim_idx,
   input  logic [9:0]          req_point_index,
   input  logic [3:0]          req_coord_index,
   input  logic signed [15:0]  req_coord_value,
   output dp_sts_type          sts,
   output logic [CIW-1:0]      asg_data,
   output logic                asg_valid
);

   localparam int CW     = COORD_WIDTH;
   localparam int PDEPTH = MAX_POINTS * MAX_DIMS;
   localparam int CDEPTH = MAX_CLUSTERS * MAX_DIMS;
   localparam int PAW    = $clog2(PDEPTH);
   localparam int CAW    = $clog2(CDEPTH);
   localparam int CNTW   = $clog2(MAX_POINTS + 1);
   localparam int SW     = CW + CNTW;
   localparam int SQW    = 2 * CW + 2;
   localparam int DW     = SQW + $clog2(MAX_DIMS + 1);
   localparam int CMPW   = (DW > 64) ? 64 : DW;
   localparam int STW    = $clog2(SW + 1);

   logic signed [CW-1:0]   point_mem [PDEPTH];
   logic signed [CW-1:0]   cen_mem   [CDEPTH];
   logic signed [SW-1:0]   sum_mem   [CDEPTH];
   logic [CNTW-1:0]        cnt_mem   [MAX_CLUSTERS];
   logic [CIW-1:0]         asg_mem   [MAX_POINTS];

   logic signed [CW-1:0]   pt_rd_ff;
   logic signed [CW-1:0]   cen_rd_ff;
   logic signed [SW-1:0]   sum_rd_ff;
   logic [CNTW-1:0]        cnt_rd_ff;
   logic [CIW-1:0]         asg_rd_ff;
   logic                   asg_ok_ff;

   logic signed [CW:0]     diff_ff;
   logic [SQW-1:0]         sq_ff;
   logic [DW-1:0]          acc_ff;
   logic [CMPW-1:0]        best_ff;
   logic [CIW-1:0]         win_ff;

   logic                   div_busy_ff;
   logic                   div_done_ff;
   logic                   div_neg_ff;
   logic [SW-1:0]          quo_ff;
   logic [CNTW-1:0]        rem_ff;
   logic [CNTW-1:0]        dvs_ff;
   logic [STW-1:0]         step_ff;

   logic [PAW-1:0]         pt_addr;
   logic [PAW-1:0]         ld_addr;
   logic                   ld_ok;
   logic [CAW-1:0]         cen_addr;
   logic [CAW-1:0]         sum_addr;
   logic [CIW-1:0]         cl_sel;
   logic [CIW-1:0]         cnt_addr;
   logic [CMPW-1:0]        acc_sat;
   logic [CNTW:0]          rem_sh;
   logic [CNTW:0]          rem_sub;
   logic [SW-1:0]          sum_mag;
   logic signed [CW-1:0]   quo_out;

   always_comb begin
      pt_addr  = PAW'(pt_idx) * PAW'(MAX_DIMS) + PAW'(dim_idx);
      ld_addr  = PAW'(req_point_index) * PAW'(MAX_DIMS) + PAW'(req_coord_index);
      ld_ok    = (32'(req_point_index) < MAX_POINTS) && (32'(req_coord_index) < MAX_DIMS);
      cl_sel   = (cmd.op == OP_SUMA_RD || cmd.op == OP_SUMA_WR) ? win_ff : cl_idx;
      cnt_addr = (cmd.op == OP_ASG_WR || cmd.op == OP_CNT_WR) ? win_ff : cl_idx;
      cen_addr = CAW'(cl_idx) * CAW'(MAX_DIMS) + CAW'(dim_idx);
      sum_addr = CAW'(cl_sel) * CAW'(MAX_DIMS) + CAW'(dim_idx);
      // squared distance saturates at 64 bits
      if ((acc_ff >> 64) != '0) begin
         acc_sat = '1;
      end else begin
         acc_sat = CMPW'(acc_ff);
      end
      rem_sh  = {rem_ff, quo_ff[SW-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      sum_mag = sum_rd_ff[SW-1] ? SW'(-sum_rd_ff) : SW'(sum_rd_ff);
      quo_out = div_neg_ff ? -CW'(quo_ff) : CW'(quo_ff);
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && ld_ok) begin
         point_mem[ld_addr] <= CW'(req_coord_value);
      end
      if (cmd.op == OP_SEED_RD || cmd.op == OP_DIST_RD || cmd.op == OP_SUMA_RD) begin
         pt_rd_ff <= point_mem[pt_addr];
      end
      if (cmd.op == OP_SEED_WR) begin
         cen_mem[cen_addr] <= pt_rd_ff;
      end else if (cmd.op == OP_UPD_WR) begin
         cen_mem[cen_addr] <= quo_out;
      end
      if (cmd.op == OP_DIST_RD) begin
         cen_rd_ff <= cen_mem[cen_addr];
      end
      if (cmd.op == OP_CLR_SUM) begin
         sum_mem[sum_addr] <= '0;
      end else if (cmd.op == OP_SUMA_WR) begin
         sum_mem[sum_addr] <= sum_rd_ff + SW'(pt_rd_ff);
      end
      if (cmd.op == OP_SUMA_RD || cmd.op == OP_UPD_RD) begin
         sum_rd_ff <= sum_mem[sum_addr];
      end
      if (cmd.op == OP_CLR_SUM && cmd.first) begin
         cnt_mem[cnt_addr] <= '0;
      end else if (cmd.op == OP_CNT_WR) begin
         cnt_mem[cnt_addr] <= cnt_rd_ff + 1'b1;
      end
      if (cmd.op == OP_ASG_WR || cmd.op == OP_CNT_RD) begin
         cnt_rd_ff <= cnt_mem[cnt_addr];
      end
      if (cmd.op == OP_ASG_CLR) begin
         asg_mem[pt_idx] <= '0;
      end else if (cmd.op == OP_ASG_WR) begin
         asg_mem[pt_idx] <= win_ff;
      end
      if (cmd.op == OP_READ) begin
         asg_rd_ff <= asg_mem[PIW'(req_point_index)];
         asg_ok_ff <= 32'(req_point_index) < MAX_POINTS;
      end
   end

   // distance pipeline and nearest-centroid select
   always_ff @(posedge clock) begin
      if (cmd.op == OP_DIST_DIFF) begin
         diff_ff <= (CW+1)'(pt_rd_ff) - (CW+1)'(cen_rd_ff);
      end
      if (cmd.op == OP_DIST_SQ) begin
         sq_ff <= SQW'(diff_ff * diff_ff);
      end
      if (cmd.op == OP_DIST_ACC) begin
         acc_ff <= (cmd.first ? '0 : acc_ff) + DW'(sq_ff);
      end
      if (cmd.op == OP_DIST_CMP && (cmd.first || acc_sat < best_ff)) begin
         best_ff <= acc_sat;
         win_ff  <= cl_idx;
      end
   end

   // restoring divider, one quotient bit per cycle on magnitudes
   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
      end else begin
         div_done_ff <= 1'b0;
         if (cmd.op == OP_DIV_START) begin
            div_busy_ff <= 1'b1;
            step_ff     <= '0;
            div_neg_ff  <= sum_rd_ff[SW-1];
            quo_ff      <= sum_mag;
            rem_ff      <= '0;
            dvs_ff      <= cnt_rd_ff;
         end else if (div_busy_ff) begin
            if (!rem_sub[CNTW]) begin
               rem_ff <= CNTW'(rem_sub);
               quo_ff <= {quo_ff[SW-2:0], 1'b1};
            end else begin
               rem_ff <= CNTW'(rem_sh);
               quo_ff <= {quo_ff[SW-2:0], 1'b0};
            end
            step_ff <= step_ff + 1'b1;
            if (step_ff == STW'(SW - 1)) begin
               div_busy_ff <= 1'b0;
               div_done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.cnt_zero = (cnt_rd_ff == '0);
   assign sts.div_done = div_done_ff;
   assign asg_data     = asg_rd_ff;
   assign asg_valid    = asg_ok_ff;

endmodule

@@ sv/kmc_control.sv @@
// ----------------------------------------------------------------------------
// kmc_control
// Configuration registers, request handshake, response register and the
// sequencer that walks seeding, assignment and update passes of a run.
// ----------------------------------------------------------------------------
module kmc_control
   import kmc_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_DIMS     = DEF_MAX_DIMS,
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   localparam int PIW  = $clog2(MAX_POINTS),
   localparam int CIW  = $clog2(MAX_CLUSTERS),
   localparam int DIW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [1:0]     req_type,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic           rsp_run_done,
   input  logic           csr_write_enable,
   input  logic [1:0]     csr_index,
   input  logic [10:0]    csr_write_data,
   output dp_cmd_type     cmd,
   output logic [PIW-1:0] pt_idx,
   output logic [CIW-1:0] cl_idx,
   output logic [DIW-1:0] dim_idx,
   input  dp_sts_type     sts
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_READ_WAIT,
      S_SEED_RD, S_SEED_WR, S_ZERO, S_CLR,
      S_DIST_RD, S_DIST_DIFF, S_DIST_SQ, S_DIST_ACC, S_DIST_CMP,
      S_ASG_WR, S_CNT_WR, S_SUMA_RD, S_SUMA_WR,
      S_UPD_CNT, S_UPD_CHK, S_UPD_RD, S_UPD_DIV, S_UPD_WAIT, S_DONE
   } state_type;

   state_type      state_ff;
   logic [10:0]    point_count_ff;
   logic [4:0]     dimensions_ff;
   logic [4:0]     cluster_count_ff;
   logic [7:0]     iteration_count_ff;
   logic [PIW-1:0] p_ff;
   logic [CIW-1:0] c_ff;
   logic [DIW-1:0] d_ff;
   logic [7:0]     it_ff;
   logic           rsp_valid_ff;
   logic           rsp_run_ff;

   logic [31:0]    n_eff;
   logic [31:0]    k_eff;
   logic [31:0]    d_eff;
   logic [PIW-1:0] n_last;
   logic [CIW-1:0] k_last;
   logic [DIW-1:0] d_last;
   logic           accept;
   logic           last_d;
   logic           last_c;
   logic           last_p;
   logic           last_it;

   always_comb begin
      if (point_count_ff == '0) begin
         n_eff = 32'd1;
      end else if (32'(point_count_ff) > MAX_POINTS) begin
         n_eff = 32'(MAX_POINTS);
      end else begin
         n_eff = 32'(point_count_ff);
      end
      if (dimensions_ff == '0) begin
         d_eff = 32'd1;
      end else if (32'(dimensions_ff) > MAX_DIMS) begin
         d_eff = 32'(MAX_DIMS);
      end else begin
         d_eff = 32'(dimensions_ff);
      end
      if (cluster_count_ff == '0) begin
         k_eff = 32'd1;
      end else if (32'(cluster_count_ff) > MAX_CLUSTERS) begin
         k_eff = 32'(MAX_CLUSTERS);
      end else begin
         k_eff = 32'(cluster_count_ff);
      end
      if (k_eff > n_eff) begin
         k_eff = n_eff;
      end
      n_last  = PIW'(n_eff - 32'd1);
      k_last  = CIW'(k_eff - 32'd1);
      d_last  = DIW'(d_eff - 32'd1);
      last_d  = (d_ff == d_last);
      last_c  = (c_ff == k_last);
      last_p  = (p_ff == n_last);
      last_it = (it_ff == iteration_count_ff - 8'd1);
      req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
      accept    = req_valid && req_ready;
   end

   // datapath commands
   always_comb begin
      cmd.first = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_type == REQ_LOAD) begin
               cmd.op = OP_LOAD;
            end else if (accept && req_type == REQ_READ) begin
               cmd.op = OP_READ;
            end else begin
               cmd.op = OP_NONE;
            end
         end
         S_CLEAR, S_ZERO: cmd.op = OP_ASG_CLR;
         S_SEED_RD:   cmd.op = OP_SEED_RD;
         S_SEED_WR:   cmd.op = OP_SEED_WR;
         S_CLR: begin
            cmd.op    = OP_CLR_SUM;
            cmd.first = (d_ff == '0);
         end
         S_DIST_RD:   cmd.op = OP_DIST_RD;
         S_DIST_DIFF: cmd.op = OP_DIST_DIFF;
         S_DIST_SQ:   cmd.op = OP_DIST_SQ;
         S_DIST_ACC: begin
            cmd.op    = OP_DIST_ACC;
            cmd.first = (d_ff == '0);
         end
         S_DIST_CMP: begin
            cmd.op    = OP_DIST_CMP;
            cmd.first = (c_ff == '0);
         end
         S_ASG_WR:    cmd.op = OP_ASG_WR;
         S_CNT_WR:    cmd.op = OP_CNT_WR;
         S_SUMA_RD:   cmd.op = OP_SUMA_RD;
         S_SUMA_WR:   cmd.op = OP_SUMA_WR;
         S_UPD_CNT:   cmd.op = OP_CNT_RD;
         S_UPD_RD:    cmd.op = OP_UPD_RD;
         S_UPD_DIV:   cmd.op = OP_DIV_START;
         S_UPD_WAIT:  cmd.op = sts.div_done ? OP_UPD_WR : OP_NONE;
         default:     cmd.op = OP_NONE;
      endcase
      // seeding copies point c into centroid c
      pt_idx  = (state_ff == S_SEED_RD) ? PIW'(c_ff) : p_ff;
      cl_idx  = c_ff;
      dim_idx = d_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff     <= RST_POINT_COUNT;
         dimensions_ff      <= RST_DIMENSIONS;
         cluster_count_ff   <= RST_CLUSTER_COUNT;
         iteration_count_ff <= RST_ITERATION_COUNT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POINT_COUNT:     point_count_ff     <= csr_write_data;
            CSR_DIMENSIONS:      dimensions_ff      <= csr_write_data[4:0];
            CSR_CLUSTER_COUNT:   cluster_count_ff   <= csr_write_data[4:0];
            CSR_ITERATION_COUNT: iteration_count_ff <= csr_write_data[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         p_ff         <= '0;
         c_ff         <= '0;
         d_ff         <= '0;
         it_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_run_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               if (p_ff == PIW'(MAX_POINTS - 1)) begin
                  p_ff     <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  p_ff <= p_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (accept && req_type == REQ_RUN) begin
                  c_ff     <= '0;
                  d_ff     <= '0;
                  state_ff <= S_SEED_RD;
               end else if (accept && req_type == REQ_READ) begin
                  state_ff <= S_READ_WAIT;
               end
            end
            S_READ_WAIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_run_ff   <= 1'b0;
               state_ff     <= S_IDLE;
            end
            S_SEED_RD: state_ff <= S_SEED_WR;
            S_SEED_WR: begin
               state_ff <= S_SEED_RD;
               if (last_d) begin
                  d_ff <= '0;
                  if (last_c) begin
                     c_ff     <= '0;
                     p_ff     <= '0;
                     state_ff <= S_ZERO;
                  end else begin
                     c_ff <= c_ff + 1'b1;
                  end
               end else begin
                  d_ff <= d_ff + 1'b1;
               end
            end
            S_ZERO: begin
               if (last_p) begin
                  p_ff  <= '0;
                  it_ff <= '0;
                  state_ff <= (iteration_count_ff == '0) ? S_DONE : S_CLR;
               end else begin
                  p_ff <= p_ff + 1'b1;
               end
            end
            S_CLR: begin
               if (last_d) begin
                  d_ff <= '0;
                  if (last_c) begin
                     c_ff     <= '0;
                     p_ff     <= '0;
                     state_ff <= S_DIST_RD;
                  end else begin
                     c_ff <= c_ff + 1'b1;
                  end
               end else begin
                  d_ff <= d_ff + 1'b1;
               end
            end
            S_DIST_RD:   state_ff <= S_DIST_DIFF;
            S_DIST_DIFF: state_ff <= S_DIST_SQ;
            S_DIST_SQ:   state_ff <= S_DIST_ACC;
            S_DIST_ACC: begin
               if (last_d) begin
                  d_ff     <= '0;
                  state_ff <= S_DIST_CMP;
               end else begin
                  d_ff     <= d_ff + 1'b1;
                  state_ff <= S_DIST_RD;
               end
            end
            S_DIST_CMP: begin
               if (last_c) begin
                  c_ff     <= '0;
                  state_ff <= S_ASG_WR;
               end else begin
                  c_ff     <= c_ff + 1'b1;
                  state_ff <= S_DIST_RD;
               end
            end
            S_ASG_WR:  state_ff <= S_CNT_WR;
            S_CNT_WR:  state_ff <= S_SUMA_RD;
            S_SUMA_RD: state_ff <= S_SUMA_WR;
            S_SUMA_WR: begin
               if (last_d) begin
                  d_ff <= '0;
                  if (last_p) begin
                     p_ff     <= '0;
                     c_ff     <= '0;
                     state_ff <= S_UPD_CNT;
                  end else begin
                     p_ff     <= p_ff + 1'b1;
                     state_ff <= S_DIST_RD;
                  end
               end else begin
                  d_ff     <= d_ff + 1'b1;
                  state_ff <= S_SUMA_RD;
               end
            end
            S_UPD_CNT: state_ff <= S_UPD_CHK;
            S_UPD_CHK: begin
               // an empty cluster keeps its centroid
               if (!sts.cnt_zero) begin
                  state_ff <= S_UPD_RD;
               end else if (!last_c) begin
                  c_ff     <= c_ff + 1'b1;
                  state_ff <= S_UPD_CNT;
               end else begin
                  c_ff     <= '0;
                  it_ff    <= it_ff + 1'b1;
                  state_ff <= last_it ? S_DONE : S_CLR;
               end
            end
            S_UPD_RD:  state_ff <= S_UPD_DIV;
            S_UPD_DIV: state_ff <= S_UPD_WAIT;
            S_UPD_WAIT: begin
               if (sts.div_done) begin
                  if (!last_d) begin
                     d_ff     <= d_ff + 1'b1;
                     state_ff <= S_UPD_RD;
                  end else if (!last_c) begin
                     d_ff     <= '0;
                     c_ff     <= c_ff + 1'b1;
                     state_ff <= S_UPD_CNT;
                  end else begin
                     d_ff     <= '0;
                     c_ff     <= '0;
                     it_ff    <= it_ff + 1'b1;
                     state_ff <= last_it ? S_DONE : S_CLR;
                  end
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_run_ff   <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_run_done = rsp_run_ff;

   a_read_waits: assert property (@(posedge clock) disable iff (reset)
      accept && req_type == REQ_READ |=> state_ff == S_READ_WAIT)
      else $error("read transaction did not start the assignment read");

   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req_type == REQ_RUN |=> state_ff == S_SEED_RD && c_ff == '0)
      else $error("run transaction did not start seeding");

   a_cluster_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIST_CMP |-> c_ff <= k_last)
      else $error("cluster counter beyond effective cluster count");

endmodule
